### sv/pbu_pkg.sv
// pbu_pkg: types, constants and codes of the belief update block
// no dependencies
`default_nettype none
package pbu_pkg;
  localparam int NUM_STATES       = 16;
  localparam int NUM_ACTIONS      = 4;
  localparam int NUM_OBSERVATIONS = 4;
  localparam int FRAC_BITS        = 16;
  localparam int PW  = FRAC_BITS + 1;
  localparam int SW  = $clog2(NUM_STATES);
  localparam int AW  = 2;
  localparam int OW  = 2;
  localparam int TDEPTH = NUM_STATES * NUM_ACTIONS * NUM_STATES;
  localparam int ODEPTH = NUM_ACTIONS * NUM_STATES * NUM_OBSERVATIONS;
  localparam int TAW = $clog2(TDEPTH);
  localparam int OAW = $clog2(ODEPTH);
  localparam int ACCW = 2 * FRAC_BITS + 2;
  localparam int SUMW = PW + SW;
  localparam logic [PW-1:0] ONE_FX = PW'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    OP_LOAD_T   = 2'd0,
    OP_LOAD_O   = 2'd1,
    OP_LOAD_B   = 2'd2,
    OP_UPDATE   = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAC_RD, ST_MAC, ST_OBS_RD, ST_OBS, ST_U,
    ST_DIV_START, ST_DIV, ST_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic [SUMW+FRAC_BITS-1:0] dividend;
    logic [SUMW-1:0]           divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [SUMW+FRAC_BITS-1:0] quotient;
  } div_rsp_t;

  function automatic logic [PW-1:0] clamp_prob(input logic [SUMW+FRAC_BITS-1:0] v);
    clamp_prob = (v > (SUMW+FRAC_BITS)'(ONE_FX)) ? ONE_FX : v[PW-1:0];
  endfunction
endpackage
`default_nettype wire

### sv/pbu_if.sv
// pbu_if: valid/ready channel interfaces for input requests and results
// no dependencies
`default_nettype none
interface pbu_in_if;
  logic valid;
  logic ready;
  logic [1:0] opcode;
  logic [3:0] from_state;
  logic [3:0] to_state;
  logic [1:0] action;
  logic [1:0] observation;
  logic [16:0] prob_value;
  modport source(output valid, opcode, from_state, to_state, action, observation,
                 prob_value, input ready);
  modport sink(input valid, opcode, from_state, to_state, action, observation,
               prob_value, output ready);
endinterface

interface pbu_out_if;
  logic valid;
  logic ready;
  logic [3:0] state_index;
  logic [16:0] belief_value;
  logic [16:0] obs_likelihood;
  logic last;
  modport source(output valid, state_index, belief_value, obs_likelihood, last,
                 input ready);
  modport sink(input valid, state_index, belief_value, obs_likelihood, last,
               output ready);
endinterface
`default_nettype wire

### sv/pbu_ram.sv
// pbu_ram: generic single-write, single-read RAM with registered read
// no dependencies
`default_nettype none
module pbu_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### sv/pbu_div.sv
// pbu_div: restoring divider, one quotient bit per cycle
// depends on pbu_pkg
`default_nettype none
module pbu_div (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pbu_pkg::div_req_t req,
  output pbu_pkg::div_rsp_t  rsp
);
  import pbu_pkg::*;
  localparam int QW = SUMW + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0]   quo_r, quo_nxt;
  logic [SUMW:0]   rem_r, rem_nxt;
  logic [SUMW-1:0] dsr_r, dsr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [SUMW:0]   trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[SUMW-1:0], quo_r[QW-1]};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      cnt_nxt  = CW'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract when it fits
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = trial - {1'b0, dsr_r};
        quo_nxt = {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
endmodule
`default_nettype wire

### sv/pomdp_belief_update.sv
// pomdp_belief_update: top level, sequencer around one shared multiplier and a divider
// depends on pbu_pkg, pbu_if, pbu_ram, pbu_div
//
// usage:
//   in channel (valid/ready): opcode 0/1/2 load transition, observation or belief
//   entries; opcode 3 runs a belief update for an action and observation.
//   out channel (valid/ready): one result per state in state order, last on the
//   final state, each with the new belief and the observation likelihood.
//   cfg port: cfg_we writes drop_threshold from cfg_wdata; write only when idle.
// sequence:
//   a load is written as it is accepted and is followed at once by the next request.
//   an update runs, per state, a multiply-accumulate over the NUM_STATES previous
//   states (ST_MAC_RD, ST_MAC), then the observation product and drop check (ST_OBS_RD,
//   ST_OBS, ST_U); then, per state, one divider pass plus the output handshake.
//   the update time is set by the single multiplier and the bit-serial divider.
//   in_ready is low during an update.
// reset: control state and drop_threshold clear; tables are undefined until loaded.
// a stalled receiver holds the current result and the sequencer waits.
`default_nettype none
module pomdp_belief_update (
  input  wire logic        clk,
  input  wire logic        rst_n,
  pbu_in_if.sink           in_ch,
  pbu_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [16:0] cfg_wdata
);
  import pbu_pkg::*;

  state_t state_r, state_nxt;
  logic [PW-1:0]   thr_r;
  logic [1:0]      act_r;
  logic [1:0]      obs_r;
  logic [SW-1:0]   s_r, s_nxt;
  logic [SW-1:0]   p_r, p_nxt;
  logic [ACCW-1:0] acc_r, acc_nxt;
  logic [SUMW-1:0] sum_r, sum_nxt;
  logic [PW-1:0]   bel_r, bel_nxt;
  logic [2*PW-1:0] prod_r;
  logic [PW-1:0]   mul_a, mul_b;

  logic in_fire, out_fire;
  logic [PW-1:0] lval;
  logic t_we, o_we, b_we, u_we;
  logic [TAW-1:0] t_waddr, t_raddr;
  logic [OAW-1:0] o_waddr, o_raddr;
  logic [SW-1:0]  b_waddr, b_raddr, u_waddr;
  logic [PW-1:0]  b_wdata, u_wdata;
  logic [PW-1:0]  t_rdata, o_rdata, b_rdata, u_rdata;
  div_req_t dreq;
  div_rsp_t drsp;
  logic [ACCW-1:0] cap, acc_add;
  logic [ACCW-FRAC_BITS-1:0] pred_raw;
  logic [PW-1:0] pred;
  logic [PW:0]   u_raw;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign lval = (in_ch.prob_value > ONE_FX) ? ONE_FX : in_ch.prob_value;
  assign cap  = ACCW'(ONE_FX) << FRAC_BITS;

  // load writes
  always_comb begin
    t_we    = in_fire && (opcode_t'(in_ch.opcode) == OP_LOAD_T);
    o_we    = in_fire && (opcode_t'(in_ch.opcode) == OP_LOAD_O);
    t_waddr = {in_ch.from_state, in_ch.action, in_ch.to_state};
    o_waddr = {in_ch.action, in_ch.to_state, in_ch.observation};
  end

  assign t_raddr = {p_r, act_r, s_r};
  assign o_raddr = {act_r, s_r, obs_r};
  assign b_raddr = p_r;

  pbu_ram #(.WIDTH(PW), .DEPTH(TDEPTH)) u_tram (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(lval), .raddr(t_raddr), .rdata(t_rdata));
  pbu_ram #(.WIDTH(PW), .DEPTH(ODEPTH)) u_oram (
    .clk, .we(o_we), .waddr(o_waddr), .wdata(lval), .raddr(o_raddr), .rdata(o_rdata));
  pbu_ram #(.WIDTH(PW), .DEPTH(NUM_STATES)) u_bram (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(b_raddr), .rdata(b_rdata));
  // read one state ahead so the entry for s_r is ready at divider start
  pbu_ram #(.WIDTH(PW), .DEPTH(NUM_STATES)) u_uram (
    .clk, .we(u_we), .waddr(u_waddr), .wdata(u_wdata), .raddr(s_nxt), .rdata(u_rdata));

  pbu_div u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

  // shared multiplier operands, registered product
  always_comb begin
    mul_a = t_rdata;
    mul_b = b_rdata;
    if (state_r == ST_OBS) begin
      mul_a = o_rdata;
      mul_b = pred;
    end
  end
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_comb begin
    acc_add  = acc_r + ACCW'(prod_r);
    pred_raw = acc_r[ACCW-1:FRAC_BITS];
    pred     = (pred_raw > (ACCW-FRAC_BITS)'(ONE_FX)) ? ONE_FX : pred_raw[PW-1:0];
    u_raw    = prod_r[FRAC_BITS +: PW+1];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_fire && opcode_t'(in_ch.opcode) == OP_UPDATE) state_nxt = ST_MAC_RD;
      ST_MAC_RD:    state_nxt = ST_MAC;
      ST_MAC:       state_nxt = (p_r == SW'(NUM_STATES-1)) ? ST_OBS_RD : ST_MAC_RD;
      ST_OBS_RD:    state_nxt = ST_OBS;
      ST_OBS:       state_nxt = ST_U;
      ST_U:         state_nxt = (s_r == SW'(NUM_STATES-1)) ? ST_DIV_START : ST_MAC_RD;
      ST_DIV_START: state_nxt = ST_DIV;
      ST_DIV:       if (drsp.done) state_nxt = ST_EMIT;
      ST_EMIT:      if (out_fire) begin
        state_nxt = (s_r == SW'(NUM_STATES-1)) ? ST_IDLE : ST_DIV_START;
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    s_nxt   = s_r;
    p_nxt   = p_r;
    acc_nxt = acc_r;
    sum_nxt = sum_r;
    bel_nxt = bel_r;
    u_we    = 1'b0;
    u_waddr = s_r;
    u_wdata = '0;
    b_we    = in_fire && (opcode_t'(in_ch.opcode) == OP_LOAD_B);
    b_waddr = in_ch.to_state;
    b_wdata = lval;
    dreq.start    = 1'b0;
    dreq.dividend = (SUMW+FRAC_BITS)'(u_rdata) << FRAC_BITS;
    dreq.divisor  = sum_r;
    unique case (state_r)
      ST_IDLE: begin
        s_nxt = '0; p_nxt = '0; acc_nxt = '0; sum_nxt = '0;
      end
      ST_MAC_RD: ;
      ST_MAC: begin
        // read data is registered; product is added in ST_MAC_RD or ST_OBS_RD
        p_nxt = p_r + SW'(1);
      end
      ST_OBS_RD: ;
      ST_OBS: ;
      ST_U: begin
        u_we    = 1'b1;
        u_wdata = (u_raw > (PW+1)'(thr_r)) ? u_raw[PW-1:0] : '0;
        sum_nxt = sum_r + SUMW'(u_wdata);
        acc_nxt = '0;
        p_nxt   = '0;
        s_nxt   = (s_r == SW'(NUM_STATES-1)) ? '0 : s_r + SW'(1);
      end
      ST_DIV_START: begin
        dreq.start = 1'b1;
      end
      ST_DIV: begin
        if (drsp.done) begin
          bel_nxt = (sum_r == '0) ? '0 : clamp_prob(drsp.quotient);
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          b_we    = 1'b1;
          b_waddr = s_r;
          b_wdata = bel_r;
          s_nxt   = s_r + SW'(1);
        end
      end
      default: ;
    endcase
    // accumulate the product of the previous read pair
    if (state_r == ST_MAC_RD && p_r != '0) begin
      acc_nxt = (acc_add > cap) ? cap : acc_add;
    end
    if (state_r == ST_OBS_RD) begin
      acc_nxt = (acc_add > cap) ? cap : acc_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      thr_r   <= '0;
      act_r   <= '0;
      obs_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (in_fire) begin
        act_r <= in_ch.action;
        obs_r <= in_ch.observation;
      end
    end
    s_r   <= s_nxt;
    p_r   <= p_nxt;
    acc_r <= acc_nxt;
    sum_r <= sum_nxt;
    bel_r <= bel_nxt;
  end

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = (state_r == ST_EMIT);
  assign out_ch.state_index    = s_r;
  assign out_ch.belief_value   = bel_r;
  assign out_ch.obs_likelihood = (sum_r > SUMW'(ONE_FX)) ? ONE_FX : sum_r[PW-1:0];
  assign out_ch.last           = (s_r == SW'(NUM_STATES-1));

`ifndef NO_ASSERTIONS
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ch.ready) else $error("ready during update");
  a_belief_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.belief_value <= ONE_FX)) else $error("belief above one");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.state_index))
    else $error("result index moved while stalled");
`endif
endmodule
`default_nettype wire
